/* rtl/core/fse_pkg.sv */
// ----------------------------------------------------------------------------
// fse_pkg
// Shared constants, codes and types for the FIR smoother with edge modes.
// ----------------------------------------------------------------------------
package fse_pkg;

    localparam int MAX_TAPS        = 31;
    localparam int SAMPLE_BITS     = 16;
    localparam int COEFF_FRAC_BITS = 15;
    localparam int COEFF_BITS      = 16;
    localparam int TAP_BITS        = 5;
    localparam int EDGE_BITS       = 2;
    localparam int COUNT_BITS      = 16;
    localparam int ADDR_BITS       = 3;
    localparam int DATA_BITS       = 32;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [EDGE_BITS-1:0] EDGE_PAD    = 2'd0;
    localparam logic [EDGE_BITS-1:0] EDGE_CLAMP  = 2'd1;
    localparam logic [EDGE_BITS-1:0] EDGE_MIRROR = 2'd2;

    localparam logic REG_TAP_COUNT = 1'b0;
    localparam logic REG_EDGE_MODE = 1'b1;

    localparam logic [TAP_BITS-1:0] TAP_COUNT_RESET = 5'd3;

    typedef struct packed {
        logic                          operation;
        logic [TAP_BITS-1:0]           coeff_index;
        logic signed [COEFF_BITS-1:0]  coeff_value;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_sample;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] smoothed;
        logic                          saturated;
        logic                          last_of_column;
    } t_out;

    typedef struct packed {
        logic capture_load;
        logic capture_sample;
        logic plan;
        logic start;
        logic issue;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic has_output;
        logic last_tap;
        logic pipe_busy;
        logic out_free;
        logic final_out;
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAN,
        ST_START,
        ST_TAPS,
        ST_DRAIN,
        ST_EMIT
    } t_state;

endpackage

/* rtl/core/fir_smoother_with_edge_modes.sv */
// ----------------------------------------------------------------------------
// fir_smoother_with_edge_modes
// Streaming odd-length FIR smoother over one column of signed samples, with
// zero, clamp or reflect handling past the column ends.
//
//   channel  direction  handshake                     beat
//   in       sink       i_in_valid / o_in_ready       fse_pkg::t_in
//   out      source     o_out_valid / i_out_ready     fse_pkg::t_out
//   cfg      sink       APB psel/penable/pwrite       tap_count @0, edge_mode @4
//
// A coefficient load is taken in the idle state. A sample beat is captured
// and planned; each output it causes then starts, walks the taps through one
// shared multiply-accumulate, drains the memory/multiply pipe and emits.
// The last sample of a column causes up to half + 1 outputs.
// Reset is synchronous, active low; memories are not cleared.
// A full output register holds the sequencer only when the next result is
// ready; input beats are taken again as soon as the last output is loaded.
// ----------------------------------------------------------------------------
module fir_smoother_with_edge_modes #(
    parameter int MAX_TAPS        = fse_pkg::MAX_TAPS,
    parameter int COEFF_FRAC_BITS = fse_pkg::COEFF_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  fse_pkg::t_in                      i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output fse_pkg::t_out                     o_out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fse_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [fse_pkg::DATA_BITS-1:0]     pwdata,
    output logic [fse_pkg::DATA_BITS-1:0]     prdata,
    output logic                              pready
);

    logic [fse_pkg::TAP_BITS-1:0]  r_tap_count;
    logic [fse_pkg::EDGE_BITS-1:0] r_edge_mode;
    logic                          cfg_wr;
    fse_pkg::t_cmd                 cmd;
    fse_pkg::t_status              status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= fse_pkg::TAP_COUNT_RESET;
            r_edge_mode <= fse_pkg::EDGE_PAD;
        end else if (cfg_wr) begin
            case (paddr[2])
                fse_pkg::REG_TAP_COUNT: begin
                    r_tap_count <= pwdata[fse_pkg::TAP_BITS-1:0];
                end
                fse_pkg::REG_EDGE_MODE: begin
                    r_edge_mode <= pwdata[fse_pkg::EDGE_BITS-1:0];
                end
                default: begin
                    r_tap_count <= r_tap_count;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            fse_pkg::REG_TAP_COUNT: prdata = fse_pkg::DATA_BITS'(r_tap_count);
            fse_pkg::REG_EDGE_MODE: prdata = fse_pkg::DATA_BITS'(r_edge_mode);
            default:                prdata = '0;
        endcase
    end

    fse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_op    (i_in_data.operation),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    fse_dp #(
        .MAX_TAPS        (MAX_TAPS),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_taps  (r_tap_count),
        .i_cfg_edge  (r_edge_mode),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* rtl/core/fse_ram.sv */
// ----------------------------------------------------------------------------
// fse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fse_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 31,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/fse_ctrl.sv */
// ----------------------------------------------------------------------------
// fse_ctrl
// Sequencer: accepts beats, plans outputs, walks taps, drains and emits.
// ----------------------------------------------------------------------------
module fse_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_op,
    input  fse_pkg::t_status i_status,
    output fse_pkg::t_cmd    o_cmd,
    output logic             o_in_ready
);

    fse_pkg::t_state r_state;
    fse_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fse_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fse_pkg::ST_IDLE: begin
                if (i_in_valid && (i_in_op == fse_pkg::OP_SAMPLE)) begin
                    n_state = fse_pkg::ST_PLAN;
                end
            end
            fse_pkg::ST_PLAN: begin
                n_state = i_status.has_output ? fse_pkg::ST_START : fse_pkg::ST_IDLE;
            end
            fse_pkg::ST_START: begin
                n_state = fse_pkg::ST_TAPS;
            end
            fse_pkg::ST_TAPS: begin
                if (i_status.last_tap) begin
                    n_state = fse_pkg::ST_DRAIN;
                end
            end
            fse_pkg::ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = fse_pkg::ST_EMIT;
                end
            end
            fse_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = i_status.final_out ? fse_pkg::ST_IDLE : fse_pkg::ST_START;
                end
            end
            default: begin
                n_state = fse_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            fse_pkg::ST_IDLE: begin
                o_in_ready           = 1'b1;
                o_cmd.capture_load   = i_in_valid && (i_in_op == fse_pkg::OP_LOAD);
                o_cmd.capture_sample = i_in_valid && (i_in_op == fse_pkg::OP_SAMPLE);
            end
            fse_pkg::ST_PLAN: begin
                o_cmd.plan = 1'b1;
            end
            fse_pkg::ST_START: begin
                o_cmd.start = 1'b1;
            end
            fse_pkg::ST_TAPS: begin
                o_cmd.issue = 1'b1;
            end
            fse_pkg::ST_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/core/fse_dp.sv */
// ----------------------------------------------------------------------------
// fse_dp
// Datapath: kernel and sample memories, edge-mode index mapping, shared
// multiply-accumulate, rounding, saturation and the output register.
// ----------------------------------------------------------------------------
module fse_dp #(
    parameter int MAX_TAPS        = fse_pkg::MAX_TAPS,
    parameter int COEFF_FRAC_BITS = fse_pkg::COEFF_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [fse_pkg::TAP_BITS-1:0]      i_cfg_taps,
    input  logic [fse_pkg::EDGE_BITS-1:0]     i_cfg_edge,
    input  fse_pkg::t_in                      i_in_data,
    input  fse_pkg::t_cmd                     i_cmd,
    output fse_pkg::t_status                  o_status,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output fse_pkg::t_out                     o_out_data
);

    localparam int SB    = fse_pkg::SAMPLE_BITS;
    localparam int CB    = fse_pkg::COEFF_BITS;
    localparam int TB    = fse_pkg::TAP_BITS;
    localparam int NB    = fse_pkg::COUNT_BITS;
    localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int LIM   = (MAX_TAPS % 2 == 1) ? MAX_TAPS : MAX_TAPS - 1;
    localparam int IW    = NB + 3;
    localparam int PW    = SB + CB;
    localparam int ACC_W = SB + CB + TB;

    localparam logic signed [ACC_W-1:0] RND_ADD =
        ACC_W'(64'sd1 <<< (COEFF_FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] HI_LIM =
        ACC_W'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] LO_LIM = -HI_LIM - ACC_W'(1);
    localparam logic [AW:0] WRAP = (AW + 1)'(MAX_TAPS);
    localparam logic [AW:0] TOP  = (AW + 1)'(MAX_TAPS - 1);

    logic [NB-1:0]          r_seen;
    logic [AW-1:0]          r_head;
    logic                   r_at_end;
    logic [NB-1:0]          r_out_idx;
    logic signed [IW-1:0]   r_idx;
    logic [TB-1:0]          r_tap;
    logic                   r_s1_vld;
    logic                   r_s1_use;
    logic signed [IW-1:0]   r_s1_adj;
    logic [TB-1:0]          r_s1_tap;
    logic                   r_s2_vld;
    logic                   r_s2_use;
    logic                   r_s3_vld;
    logic                   r_s3_use;
    logic signed [PW-1:0]   r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic                   r_out_valid;
    fse_pkg::t_out          r_out;

    logic [TB-1:0]          t_odd;
    logic [TB-1:0]          taps;
    logic [TB-2:0]          half;
    logic signed [IW-1:0]   half_s;
    logic signed [IW-1:0]   latest;
    logic signed [IW-1:0]   latest2;
    logic signed [IW-1:0]   plan_idx;
    logic signed [IW-1:0]   out_idx_s;
    logic                   at_latest;

    logic                   neg;
    logic                   over;
    logic                   outside;
    logic signed [IW-1:0]   clampd;
    logic signed [IW-1:0]   refl;
    logic signed [IW-1:0]   adj;
    logic                   use_tap;

    logic signed [IW-1:0]   off;
    logic [AW:0]            pos_sum;
    logic [AW-1:0]          pos;

    logic                   coef_we;
    logic [CB-1:0]          coef_q;
    logic [SB-1:0]          win_q;

    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] q;
    logic                   sat_hi;
    logic                   sat_lo;
    fse_pkg::t_out          result;

    // tap count in use and half width
    always_comb begin
        t_odd = i_cfg_taps | TB'(1);
        taps  = (int'(t_odd) > LIM) ? TB'(LIM) : t_odd;
        half  = taps[TB-1:1];
    end

    assign half_s    = $signed(IW'(half));
    assign latest    = $signed(IW'(r_seen)) - IW'(1);
    assign latest2   = latest + latest;
    assign out_idx_s = $signed(IW'(r_out_idx));
    assign at_latest = (out_idx_s == latest);

    always_comb begin
        plan_idx = latest - half_s;
        if (r_at_end && (plan_idx < 0)) begin
            plan_idx = '0;
        end
    end

    // edge-mode mapping of the neighbor index
    always_comb begin
        neg     = (r_idx < 0);
        over    = r_at_end && (r_idx > latest);
        outside = neg || over;
        if (neg) begin
            clampd = '0;
        end else if (r_idx > latest) begin
            clampd = latest;
        end else begin
            clampd = r_idx;
        end
        refl = neg ? -r_idx : r_idx;
        if (r_at_end && (refl > latest)) begin
            refl = latest2 - refl;
        end
        if (refl < 0) begin
            refl = '0;
        end else if (refl > latest) begin
            refl = latest;
        end
        case (i_cfg_edge)
            fse_pkg::EDGE_CLAMP: begin
                adj     = outside ? clampd : r_idx;
                use_tap = 1'b1;
            end
            fse_pkg::EDGE_MIRROR: begin
                adj     = outside ? refl : r_idx;
                use_tap = 1'b1;
            end
            default: begin
                adj     = r_idx;
                use_tap = !outside;
            end
        endcase
    end

    // window slot of the mapped index
    always_comb begin
        off     = latest - r_s1_adj;
        pos_sum = {1'b0, r_head} + TOP - {1'b0, off[AW-1:0]};
        pos     = (pos_sum >= WRAP) ? AW'(pos_sum - WRAP) : pos_sum[AW-1:0];
    end

    assign coef_we = i_cmd.capture_load && (int'(i_in_data.coeff_index) < MAX_TAPS);

    fse_ram #(
        .WIDTH (CB),
        .DEPTH (MAX_TAPS)
    ) u_kernel_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (AW'(i_in_data.coeff_index)),
        .i_wdata (i_in_data.coeff_value),
        .i_raddr (AW'(r_s1_tap)),
        .o_rdata (coef_q)
    );

    fse_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_TAPS)
    ) u_window_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.capture_sample),
        .i_waddr (r_head),
        .i_wdata (i_in_data.sample),
        .i_raddr (pos),
        .o_rdata (win_q)
    );

    // round half up, then saturate
    always_comb begin
        rnd    = r_acc + RND_ADD;
        q      = rnd >>> COEFF_FRAC_BITS;
        sat_hi = (q > HI_LIM);
        sat_lo = (q < LO_LIM);
        if (sat_hi) begin
            result.smoothed = HI_LIM[SB-1:0];
        end else if (sat_lo) begin
            result.smoothed = LO_LIM[SB-1:0];
        end else begin
            result.smoothed = q[SB-1:0];
        end
        result.saturated      = sat_hi || sat_lo;
        result.last_of_column = r_at_end && at_latest;
    end

    // column counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen   <= '0;
            r_head   <= '0;
            r_at_end <= 1'b0;
        end else if (i_cmd.capture_sample) begin
            r_at_end <= i_in_data.last_sample;
            r_head   <= (int'(r_head) == MAX_TAPS - 1) ? '0 : r_head + AW'(1);
            if (r_seen != '1) begin
                r_seen <= r_seen + NB'(1);
            end
        end else if (i_cmd.emit && r_at_end && at_latest) begin
            r_seen <= '0;
            r_head <= '0;
        end
    end

    // output index, tap walk and accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.plan) begin
            r_out_idx <= plan_idx[NB-1:0];
        end else if (i_cmd.emit) begin
            r_out_idx <= r_out_idx + NB'(1);
        end
        if (i_cmd.start) begin
            r_idx <= out_idx_s - half_s;
            r_tap <= '0;
        end else if (i_cmd.issue) begin
            r_idx <= r_idx + IW'(1);
            r_tap <= r_tap + TB'(1);
        end
        r_s1_use <= use_tap;
        r_s1_adj <= adj;
        r_s1_tap <= r_tap;
        r_s2_use <= r_s1_use;
        r_s3_use <= r_s2_use;
        r_prod   <= $signed(win_q) * $signed(coef_q);
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_s3_vld && r_s3_use) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.issue;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= result;
        end
    end

    assign o_status.has_output = r_at_end || (r_seen > NB'(half));
    assign o_status.last_tap   = (r_tap == taps - TB'(1));
    assign o_status.pipe_busy  = r_s1_vld || r_s2_vld || r_s3_vld;
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_status.final_out  = !r_at_end || at_latest;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* test/tb_fir_smoother_with_edge_modes.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fir_smoother_with_edge_modes
// Self-checking bench for the streaming FIR smoother. Drives kernel loads and
// column samples through the input channel and programs tap count and edge
// mode over APB. A built-in model of the smoother predicts every smoothed
// beat, and each beat taken from the output channel is compared with it.
// Covers extremes, rounding ties, odd/even tap counts, all edge modes, short
// reflected columns and output back-pressure.
// ----------------------------------------------------------------------------
module tb_fir_smoother_with_edge_modes;

    localparam int TAP_LIMIT     = (fse_pkg::MAX_TAPS % 2) ? fse_pkg::MAX_TAPS
                                                           : fse_pkg::MAX_TAPS - 1;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 2 * (fse_pkg::MAX_TAPS + 8);
    localparam int RANDOM_ITEMS  = 50;
    localparam int HOLD_CYCLES   = 300;
    localparam int COUNT_MAX     = (1 << fse_pkg::COUNT_BITS) - 1;

    localparam logic [fse_pkg::EDGE_BITS-1:0] EDGE_PAD_ALT = 2'd3;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_ready;
    fse_pkg::t_in                   i_in_data;
    logic                           o_out_valid;
    logic                           i_out_ready;
    fse_pkg::t_out                  o_out_data;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [fse_pkg::ADDR_BITS-1:0]  paddr;
    logic [fse_pkg::DATA_BITS-1:0]  pwdata;
    logic [fse_pkg::DATA_BITS-1:0]  prdata;
    logic                           pready;

    // smoother state as seen by the bench
    logic [fse_pkg::TAP_BITS-1:0]           taps_reg = fse_pkg::TAP_COUNT_RESET;
    logic [fse_pkg::EDGE_BITS-1:0]          edge_reg = fse_pkg::EDGE_PAD;
    logic signed [fse_pkg::COEFF_BITS-1:0]  coeffs [fse_pkg::MAX_TAPS];
    bit   [fse_pkg::MAX_TAPS-1:0]           coeff_set = '0;
    logic signed [fse_pkg::SAMPLE_BITS-1:0] recent [fse_pkg::MAX_TAPS];
    int                                     recent_head = 0;
    int                                     seen_count = 0;
    fse_pkg::t_out                          owed [$];

    int mismatches = 0;
    int items_sent = 0;
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int rx_hold_len = 0;

    fir_smoother_with_edge_modes dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void flag_mismatch(string what,
                                          logic [fse_pkg::DATA_BITS-1:0] want,
                                          logic [fse_pkg::DATA_BITS-1:0] got);
        mismatches++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    endfunction

    function automatic int taps_used();
        int t;
        t = int'(taps_reg) | 1;
        if (t > TAP_LIMIT) begin
            t = TAP_LIMIT;
        end
        return t;
    endfunction

    function automatic fse_pkg::t_out convolve_at(longint center, longint latest,
                                                  bit at_end, bit last);
        int            taps;
        int            pos;
        longint        half;
        longint        idx;
        longint        off;
        longint        acc;
        longint        q;
        fse_pkg::t_out res;
        taps = taps_used();
        half = (taps - 1) / 2;
        acc  = 0;
        res.saturated = 1'b0;
        for (int t = 0; t < taps; t++) begin
            idx = center - half + t;
            if (idx < 0 || (at_end && idx > latest)) begin
                if (edge_reg == fse_pkg::EDGE_CLAMP) begin
                    idx = (idx < 0) ? 0 : latest;
                end else if (edge_reg == fse_pkg::EDGE_MIRROR) begin
                    if (idx < 0) idx = -idx;
                    if (at_end && idx > latest) idx = 2 * latest - idx;
                    if (idx < 0) idx = 0;
                    if (idx > latest) idx = latest;
                end else begin
                    continue;
                end
            end
            off = latest - idx;
            if (off >= 0 && off < fse_pkg::MAX_TAPS) begin
                pos = (recent_head + fse_pkg::MAX_TAPS - 1 - int'(off)) % fse_pkg::MAX_TAPS;
                acc += longint'(recent[pos]) * longint'(coeffs[t]);
            end
        end
        q = (acc + (longint'(1) << (fse_pkg::COEFF_FRAC_BITS - 1)))
            >>> fse_pkg::COEFF_FRAC_BITS;
        if (q > (longint'(1) << (fse_pkg::SAMPLE_BITS - 1)) - 1) begin
            q = (longint'(1) << (fse_pkg::SAMPLE_BITS - 1)) - 1;
            res.saturated = 1'b1;
        end
        if (q < -(longint'(1) << (fse_pkg::SAMPLE_BITS - 1))) begin
            q = -(longint'(1) << (fse_pkg::SAMPLE_BITS - 1));
            res.saturated = 1'b1;
        end
        res.smoothed       = q[fse_pkg::SAMPLE_BITS-1:0];
        res.last_of_column = last;
        return res;
    endfunction

    function automatic void smooth_step(fse_pkg::t_in beat);
        longint latest;
        longint half;
        longint first;
        if (beat.operation == fse_pkg::OP_LOAD) begin
            if (beat.coeff_index < fse_pkg::MAX_TAPS) begin
                coeffs[beat.coeff_index]    = beat.coeff_value;
                coeff_set[beat.coeff_index] = 1'b1;
            end
            return;
        end
        recent[recent_head] = beat.sample;
        recent_head = (recent_head + 1) % fse_pkg::MAX_TAPS;
        if (seen_count < COUNT_MAX) begin
            seen_count++;
        end
        latest = longint'(seen_count) - 1;
        half   = (taps_used() - 1) / 2;
        if (!beat.last_sample) begin
            if (longint'(seen_count) > half) begin
                owed.push_back(convolve_at(latest - half, latest, 1'b0, 1'b0));
            end
        end else begin
            first = (latest - half < 0) ? 0 : latest - half;
            for (longint i = first; i <= latest; i++) begin
                owed.push_back(convolve_at(i, latest, 1'b1, i == latest));
            end
            seen_count  = 0;
            recent_head = 0;
        end
    endfunction

    function automatic logic signed [fse_pkg::SAMPLE_BITS-1:0] pick_sample();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0: begin
                return {1'b0, {(fse_pkg::SAMPLE_BITS-1){1'b1}}};
            end
            1: begin
                return {1'b1, {(fse_pkg::SAMPLE_BITS-1){1'b0}}};
            end
            default: begin
                return r[fse_pkg::SAMPLE_BITS-1:0];
            end
        endcase
    endfunction

    function automatic fse_pkg::t_in sample_beat(logic signed [fse_pkg::SAMPLE_BITS-1:0] s,
                                                 logic last);
        fse_pkg::t_in beat;
        logic [31:0]  noise;
        noise = $urandom;
        beat.operation   = fse_pkg::OP_SAMPLE;
        beat.coeff_index = noise[fse_pkg::TAP_BITS-1:0];
        beat.coeff_value = noise[31 -: fse_pkg::COEFF_BITS];
        beat.sample      = s;
        beat.last_sample = last;
        return beat;
    endfunction

    function automatic fse_pkg::t_in coeff_beat(logic [fse_pkg::TAP_BITS-1:0] idx,
                                                logic signed [fse_pkg::COEFF_BITS-1:0] val);
        fse_pkg::t_in beat;
        logic [31:0]  noise;
        noise = $urandom;
        beat.operation   = fse_pkg::OP_LOAD;
        beat.coeff_index = idx;
        beat.coeff_value = val;
        beat.sample      = noise[fse_pkg::SAMPLE_BITS-1:0];
        beat.last_sample = noise[31];
        return beat;
    endfunction

    // enter and leave on a falling edge
    task automatic offer_beat(input fse_pkg::t_in beat);
        int gap;
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        smooth_step(beat);
        if (beat.operation == fse_pkg::OP_SAMPLE || beat.coeff_index < fse_pkg::MAX_TAPS) begin
            items_sent++;
        end
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (owed.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic reg_sel,
                             input logic [fse_pkg::DATA_BITS-1:0] value);
        logic [fse_pkg::DATA_BITS-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (reg_sel == fse_pkg::REG_TAP_COUNT) begin
            taps_reg = value[fse_pkg::TAP_BITS-1:0];
        end else begin
            edge_reg = value[fse_pkg::EDGE_BITS-1:0];
        end
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        want = '0;
        if (reg_sel == fse_pkg::REG_TAP_COUNT) begin
            want[fse_pkg::TAP_BITS-1:0] = taps_reg;
        end else begin
            want[fse_pkg::EDGE_BITS-1:0] = edge_reg;
        end
        if (prdata !== want) begin
            flag_mismatch("register readback", want, prdata);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // load every kernel entry the current tap count reads but nobody wrote yet
    task automatic fill_kernel();
        logic signed [fse_pkg::COEFF_BITS-1:0] v;
        for (int k = 0; k < taps_used(); k++) begin
            if (!coeff_set[k]) begin
                v = pick_sample();
                if ($urandom_range(0, 1) == 0) begin
                    v = v >>> 3;
                end
                offer_beat(coeff_beat(k[fse_pkg::TAP_BITS-1:0], v));
            end
        end
    endtask

    task automatic test_reset_defaults();
        fse_pkg::t_in beat;
        offer_beat(coeff_beat(5'd0, 16'sh7fff));
        offer_beat(coeff_beat(5'd1, 16'sh8000));
        offer_beat(coeff_beat(5'd2, 16'sh7fff));
        // out-of-range index, with sample fields that must be ignored
        beat = coeff_beat(5'd31, 16'sh1234);
        beat.sample      = 16'sh8000;
        beat.last_sample = 1'b1;
        offer_beat(beat);
        offer_beat(sample_beat(16'sh8000, 1'b0));
        offer_beat(sample_beat(16'sh7fff, 1'b0));
        offer_beat(sample_beat(16'sh8000, 1'b0));
        offer_beat(sample_beat(16'sh7fff, 1'b1));
    endtask

    task automatic test_rounding_single_tap();
        wait_idle();
        write_reg(fse_pkg::REG_TAP_COUNT, '0);
        write_reg(fse_pkg::REG_EDGE_MODE, fse_pkg::DATA_BITS'(fse_pkg::EDGE_PAD));
        offer_beat(coeff_beat(5'd0, 16'sh4000));
        offer_beat(sample_beat(16'sd1, 1'b0));
        offer_beat(sample_beat(-16'sd1, 1'b0));
        offer_beat(sample_beat(16'sd3, 1'b0));
        offer_beat(sample_beat(-16'sd3, 1'b1));
    endtask

    task automatic test_edge_modes();
        logic [fse_pkg::EDGE_BITS-1:0] modes [3];
        modes = '{fse_pkg::EDGE_CLAMP, fse_pkg::EDGE_MIRROR, EDGE_PAD_ALT};
        wait_idle();
        write_reg(fse_pkg::REG_TAP_COUNT, 4);
        fill_kernel();
        foreach (modes[m]) begin
            wait_idle();
            write_reg(fse_pkg::REG_EDGE_MODE, fse_pkg::DATA_BITS'(modes[m]));
            for (int k = 0; k < 3; k++) begin
                offer_beat(sample_beat(pick_sample(), k == 2));
            end
        end
    endtask

    task automatic test_reflect_short_column();
        wait_idle();
        write_reg(fse_pkg::REG_TAP_COUNT, 7);
        write_reg(fse_pkg::REG_EDGE_MODE, fse_pkg::DATA_BITS'(fse_pkg::EDGE_MIRROR));
        fill_kernel();
        offer_beat(sample_beat(pick_sample(), 1'b0));
        offer_beat(sample_beat(pick_sample(), 1'b1));
        offer_beat(sample_beat(pick_sample(), 1'b1));
    endtask

    task automatic test_output_backpressure();
        wait_idle();
        tx_idle = 1'b0;
        write_reg(fse_pkg::REG_TAP_COUNT, 5);
        write_reg(fse_pkg::REG_EDGE_MODE, $urandom_range(0, 3));
        fill_kernel();
        rx_hold_len = HOLD_CYCLES;
        for (int k = 0; k < 24; k++) begin
            offer_beat(sample_beat(pick_sample(), k == 23));
        end
        tx_idle = 1'b1;
    endtask

    task automatic test_random_columns();
        int                            start;
        int                            phase;
        int                            len;
        logic [fse_pkg::DATA_BITS-1:0] cfg;
        start = items_sent;
        phase = 0;
        while (items_sent - start < RANDOM_ITEMS) begin
            wait_idle();
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            cfg = $urandom;
            case (phase)
                0: cfg[fse_pkg::TAP_BITS-1:0] = 5'd31;
                1: cfg[fse_pkg::TAP_BITS-1:0] = 5'd30;
                default: begin
                    if ($urandom_range(0, 4) == 0) begin
                        cfg[fse_pkg::TAP_BITS-1:0] = fse_pkg::TAP_BITS'($urandom_range(0, 31));
                    end else begin
                        cfg[fse_pkg::TAP_BITS-1:0] = fse_pkg::TAP_BITS'($urandom_range(0, 9));
                    end
                end
            endcase
            write_reg(fse_pkg::REG_TAP_COUNT, cfg);
            cfg = $urandom;
            write_reg(fse_pkg::REG_EDGE_MODE, cfg);
            fill_kernel();
            repeat ($urandom_range(1, 3)) begin
                len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 6) == 0) begin
                        offer_beat(coeff_beat(fse_pkg::TAP_BITS'($urandom_range(0, 31)),
                                              pick_sample()));
                    end
                    offer_beat(sample_beat(pick_sample(), k == len - 1));
                end
            end
            phase++;
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial begin : result_sink
        int gap;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            gap = rx_hold_len + (rx_idle ? $urandom_range(0, 11) : 0);
            rx_hold_len = 0;
            if (gap != 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin : result_check
        fse_pkg::t_out want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (owed.size() == 0) begin
                flag_mismatch("result with nothing owed", '0,
                              fse_pkg::DATA_BITS'(o_out_data));
            end else begin
                want = owed.pop_front();
                if (o_out_data.smoothed !== want.smoothed) begin
                    flag_mismatch("smoothed", fse_pkg::DATA_BITS'(want.smoothed),
                                  fse_pkg::DATA_BITS'(o_out_data.smoothed));
                end
                if (o_out_data.saturated !== want.saturated) begin
                    flag_mismatch("saturated", fse_pkg::DATA_BITS'(want.saturated),
                                  fse_pkg::DATA_BITS'(o_out_data.saturated));
                end
                if (o_out_data.last_of_column !== want.last_of_column) begin
                    flag_mismatch("last_of_column", fse_pkg::DATA_BITS'(want.last_of_column),
                                  fse_pkg::DATA_BITS'(o_out_data.last_of_column));
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (psel && penable && pready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        foreach (coeffs[k]) begin
            coeffs[k] = '0;
            recent[k] = '0;
        end
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_rounding_single_tap();
        test_edge_modes();
        test_reflect_short_column();
        test_output_backpressure();
        test_random_columns();

        wait_idle();
        if (mismatches == 0 && owed.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
